>>> hw/rtl/sps_pkg.sv
// Shared types and constants for the segmented prime sieve.
// Used by sps_ctrl, sps_dp and segmented_prime_sieve_top.
package sps_pkg;

	localparam int VALUE_BITS = 24;
	localparam int DIV_BITS   = 4;                       // quotient bits per divider cycle
	localparam int DIV_CYC    = VALUE_BITS / DIV_BITS;
	localparam int DCW        = $clog2(DIV_CYC + 1);

	localparam logic [1:0] ST_PRIME = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_WIDE  = 2'd2;

	typedef struct packed {
		logic [VALUE_BITS-1:0] range_low;
		logic [VALUE_BITS-1:0] range_high;
	} query_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] prime_value;
		logic [1:0]            status;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic clr_step;
		logic sieve_init;
		logic sieve_rd;
		logic sieve_next;
		logic prime_add;
		logic mark_init;
		logic mark_step;
		logic q_load;
		logic marks_clr;
		logic p_rd;
		logic sq_load;
		logic div_start;
		logic div_step;
		logic off_load;
		logic mark_win;
		logic k_next;
		logic scan;
		logic emit_prime;
		logic emit_none;
		logic emit_wide;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic n_last;
		logic comp_bit;
		logic nsq_ok;
		logic m_over;
		logic range_inv;
		logic range_wide;
		logic k_end;
		logic psq_gt_high;
		logic div_done;
		logic mark_done;
		logic mask_zero;
		logic mask_last;
		logic out_free;
	} stat_t;

endpackage

>>> hw/rtl/sps_dp.sv
// Datapath of the segmented prime sieve: factor bitmap, base prime list,
// remainder unit, window marks and result register. Depends on sps_pkg.
module sps_dp #(
	parameter int PRIME_LIMIT = 4096,
	parameter int WINDOW      = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sps_pkg::cmd_t    cmd,
	output sps_pkg::stat_t   st,
	input  sps_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_stall,
	output sps_pkg::result_t result
);
	import sps_pkg::*;

	localparam int PW = $clog2(PRIME_LIMIT + 1);
	localparam int BD = PRIME_LIMIT / 2 + 2;
	localparam int CW = $clog2(BD + 1);
	localparam int KI = $clog2(BD);
	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int OW = ((PW > IW) ? PW : IW) + 1;
	localparam int SW = (2 * PW > VALUE_BITS) ? 2 * PW : VALUE_BITS;

	logic              comp_mem [PRIME_LIMIT+1];
	logic [PW-1:0]     base_mem [BD];

	logic [PW-1:0]     n_q;
	logic [OW-1:0]     m_q;
	logic              comp_rd_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [PW-1:0]     p_rd_q;
	logic [VALUE_BITS-1:0] low_q, high_q, dvd_q;
	logic [2*PW-1:0]   psq_q;
	logic [PW-1:0]     rem_q;
	logic [DCW-1:0]    dcnt_q;
	logic [OW-1:0]     off_q;
	logic [WINDOW-1:0] marks_q;
	logic [WINDOW-1:0] mask_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [2*PW-1:0]       nsq;
	logic [VALUE_BITS-1:0] diff;
	logic [IW-1:0]         span_m1;
	logic [PW-1:0]         rem_nx;
	logic [PW:0]           rtmp;
	logic [IW-1:0]         low_idx;
	logic [WINDOW-1:0]     low_hot;
	logic [WINDOW-1:0]     mask_nx;

	assign nsq     = {{PW{1'b0}}, n_q} * {{PW{1'b0}}, n_q};
	assign diff    = high_q - low_q;
	assign span_m1 = diff[IW-1:0];

	// Advance the remainder by DIV_BITS dividend bits
	always_comb begin
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rtmp = {rem_nx, dvd_q[VALUE_BITS-1-i]};
			if (rtmp >= {1'b0, p_rd_q})
				rtmp = rtmp - {1'b0, p_rd_q};
			rem_nx = rtmp[PW-1:0];
		end
	end

	// Find the lowest remaining prime in the window
	always_comb begin
		low_idx = '0;
		low_hot = '0;
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = IW'(i);
				low_hot = '0;
				low_hot[i] = 1'b1;
			end
		end
		mask_nx = mask_q & ~low_hot;
	end

	// Factor bitmap: clear, read and mark
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			comp_mem[n_q] <= 1'b0;
		else if (cmd.mark_step)
			comp_mem[m_q[PW-1:0]] <= 1'b1;
		if (cmd.sieve_rd)
			comp_rd_q <= comp_mem[n_q];
	end

	// Base prime list
	always_ff @(posedge clk) begin
		if (cmd.prime_add)
			base_mem[count_q[KI-1:0]] <= n_q;
		if (cmd.p_rd)
			p_rd_q <= base_mem[k_q[KI-1:0]];
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			count_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sieve_init)
				n_q <= PW'(2);
			else if (cmd.clr_step || cmd.sieve_next)
				n_q <= n_q + 1'b1;
			if (cmd.prime_add)
				count_q <= count_q + 1'b1;
			if (cmd.marks_clr)
				k_q <= '0;
			else if (cmd.k_next)
				k_q <= k_q + 1'b1;
			if (cmd.emit_prime || cmd.emit_none || cmd.emit_wide)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Query payload path
	always_ff @(posedge clk) begin
		if (cmd.mark_init)
			m_q <= OW'(nsq);
		else if (cmd.mark_step)
			m_q <= m_q + OW'(n_q);
		if (cmd.q_load) begin
			low_q  <= query.range_low;
			high_q <= query.range_high;
		end
		if (cmd.sq_load)
			psq_q <= {{PW{1'b0}}, p_rd_q} * {{PW{1'b0}}, p_rd_q};
		if (cmd.div_start) begin
			rem_q  <= '0;
			dvd_q  <= low_q;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_nx;
			dvd_q  <= dvd_q << DIV_BITS;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.off_load) begin
			if (SW'(psq_q) >= SW'(low_q))
				off_q <= OW'(SW'(psq_q) - SW'(low_q));
			else if (rem_q == '0)
				off_q <= '0;
			else
				off_q <= OW'(p_rd_q - rem_q);
		end else if (cmd.mark_win) begin
			off_q <= off_q + OW'(p_rd_q);
		end
		if (cmd.marks_clr)
			marks_q <= '0;
		else if (cmd.mark_win)
			marks_q[off_q[IW-1:0]] <= 1'b1;
		if (cmd.scan) begin
			for (int i = 0; i < WINDOW; i++)
				mask_q[i] <= !marks_q[i] && (IW'(i) <= span_m1) && (i < 2 ** IW)
					&& ((low_q > VALUE_BITS'(1)) || (low_q == VALUE_BITS'(1) && i >= 1)
					|| i >= 2);
		end else if (cmd.emit_prime) begin
			mask_q <= mask_nx;
		end
		if (cmd.emit_prime) begin
			out_q.prime_value <= low_q + VALUE_BITS'(low_idx);
			out_q.status      <= ST_PRIME;
			out_q.last        <= (mask_nx == '0);
		end else if (cmd.emit_none || cmd.emit_wide) begin
			out_q.prime_value <= '0;
			out_q.status      <= cmd.emit_wide ? ST_WIDE : ST_NONE;
			out_q.last        <= 1'b1;
		end
	end

	// Status toward the controller
	always_comb begin
		st.clr_last    = (n_q == PW'(PRIME_LIMIT));
		st.n_last      = (n_q == PW'(PRIME_LIMIT));
		st.comp_bit    = comp_rd_q;
		st.nsq_ok      = (nsq <= (2*PW)'(PRIME_LIMIT));
		st.m_over      = ((m_q + OW'(n_q)) > OW'(PRIME_LIMIT));
		st.range_inv   = (low_q > high_q);
		st.range_wide  = (diff >= VALUE_BITS'(WINDOW));
		st.k_end       = (k_q == count_q);
		st.psq_gt_high = (SW'(psq_q) > SW'(high_q));
		st.div_done    = (dcnt_q == DCW'(DIV_CYC));
		st.mark_done   = (off_q > OW'(span_m1));
		st.mask_zero   = (mask_q == '0);
		st.mask_last   = (mask_nx == '0);
		st.out_free    = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> hw/rtl/sps_ctrl.sv
// Controller of the segmented prime sieve: table build after reset, then
// per-item marking and emission. Depends on sps_pkg.
module sps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           query_valid,
	output logic           query_stall,
	input  sps_pkg::stat_t st,
	output sps_pkg::cmd_t  cmd
);
	import sps_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_SRD   = 4'd1;
	localparam logic [3:0] S_SCHK  = 4'd2;
	localparam logic [3:0] S_SMARK = 4'd3;
	localparam logic [3:0] S_IDLE  = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_PRD   = 4'd6;
	localparam logic [3:0] S_SQ    = 4'd7;
	localparam logic [3:0] S_PCMP  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_OFF   = 4'd10;
	localparam logic [3:0] S_MARK  = 4'd11;
	localparam logic [3:0] S_SCAN  = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0] state_q, state_nx;

	// Decode state into datapath commands and the next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					cmd.sieve_init = 1'b1;
					state_nx = S_SRD;
				end
			end
			S_SRD: begin
				cmd.sieve_rd = 1'b1;
				state_nx = S_SCHK;
			end
			S_SCHK: begin
				cmd.prime_add = !st.comp_bit;
				if (!st.comp_bit && st.nsq_ok) begin
					cmd.mark_init = 1'b1;
					state_nx = S_SMARK;
				end else if (st.n_last) begin
					state_nx = S_IDLE;
				end else begin
					cmd.sieve_next = 1'b1;
					state_nx = S_SRD;
				end
			end
			S_SMARK: begin
				cmd.mark_step = 1'b1;
				if (st.m_over) begin
					if (st.n_last) begin
						state_nx = S_IDLE;
					end else begin
						cmd.sieve_next = 1'b1;
						state_nx = S_SRD;
					end
				end
			end
			S_IDLE: begin
				if (query_valid) begin
					cmd.q_load = 1'b1;
					state_nx = S_CHK;
				end
			end
			S_CHK: begin
				if (st.range_inv || st.range_wide) begin
					state_nx = S_EMIT;
				end else begin
					cmd.marks_clr = 1'b1;
					state_nx = S_PRD;
				end
			end
			S_PRD: begin
				if (st.k_end) begin
					state_nx = S_SCAN;
				end else begin
					cmd.p_rd = 1'b1;
					state_nx = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq_load = 1'b1;
				state_nx = S_PCMP;
			end
			S_PCMP: begin
				if (st.psq_gt_high) begin
					state_nx = S_SCAN;
				end else begin
					cmd.div_start = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = !st.div_done;
				if (st.div_done)
					state_nx = S_OFF;
			end
			S_OFF: begin
				cmd.off_load = 1'b1;
				state_nx = S_MARK;
			end
			S_MARK: begin
				if (st.mark_done) begin
					cmd.k_next = 1'b1;
					state_nx = S_PRD;
				end else begin
					cmd.mark_win = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					if (st.range_inv) begin
						cmd.emit_none = 1'b1;
						state_nx = S_IDLE;
					end else if (st.range_wide) begin
						cmd.emit_wide = 1'b1;
						state_nx = S_IDLE;
					end else if (st.mask_zero) begin
						cmd.emit_none = 1'b1;
						state_nx = S_IDLE;
					end else begin
						cmd.emit_prime = 1'b1;
						if (st.mask_last)
							state_nx = S_IDLE;
					end
				end
			end
			default: state_nx = S_CLR;
		endcase
	end

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= state_nx;
	end

	assign query_stall = (state_q != S_IDLE);

	// At most one result kind per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_prime, cmd.emit_none, cmd.emit_wide}))
		else $error("two result kinds loaded at once");

	// Never load a result into an occupied, stalled output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_prime || cmd.emit_none || cmd.emit_wide) |-> st.out_free)
		else $error("result loaded while output is stalled");

	// A window mark lands inside the range
	a_mark_in: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_win |-> !st.mark_done && !st.range_wide && !st.range_inv)
		else $error("window mark outside the range");

	// Marking follows the offset load of the same prime
	a_off_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.off_load |=> !cmd.k_next || st.mark_done)
		else $error("prime left without marking");

endmodule

>>> hw/rtl/segmented_prime_sieve_top.sv
// Segmented prime sieve: lists the primes of a small query range.
// Top level; instantiates sps_ctrl and sps_dp, depends on sps_pkg.
//
// Usage:
//  - query channel (query_valid/query_stall/query) takes one item with
//    range_low and range_high, inclusive.
//  - result channel (result_valid/result_stall/result) returns the primes of
//    the range in ascending order, last set on the final one; an empty or
//    prime-free range gives one status 1 item, a range wider than WINDOW one
//    status 2 item.
//  - After reset the block clears its factor bitmap and sieves base primes
//    up to PRIME_LIMIT, with query_stall high.
//  - One item at a time. Per base prime p with p*p <= range_high it reads
//    the list, squares p, compares, runs the remainder unit at 4 bits a
//    cycle, loads the offset and marks the window; then it scans the
//    window and emits the results.
//  - result_stall holds the result register; the block waits and nothing
//    is lost. query_stall is low only while the block is idle.
module segmented_prime_sieve_top #(
	parameter int PRIME_LIMIT = 4096,
	parameter int WINDOW      = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  sps_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_stall,
	output sps_pkg::result_t result
);
	import sps_pkg::*;

	cmd_t  cmd;
	stat_t st;

	sps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_stall (query_stall),
		.st          (st),
		.cmd         (cmd)
	);

	sps_dp #(
		.PRIME_LIMIT (PRIME_LIMIT),
		.WINDOW      (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
